### hw/rtl/url_percent_encoder_assert.svh
// assertion macros for the url percent encoder
`ifndef URL_PERCENT_ENCODER_ASSERT_SVH
`define URL_PERCENT_ENCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define UPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/urlenc_pkg.sv
// shared types, constants and helper functions of the url percent encoder
`timescale 1ns / 1ps

package urlenc_pkg;

	// command kinds passed from front to back
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_ONE   = 2'd1;
	localparam logic [1:0] KIND_THREE = 2'd2;

	// characters
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_COLON   = 8'h3a;
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_UNDER   = 8'h5f;
	localparam logic [7:0] CH_STAR    = 8'h2a;
	localparam logic [7:0] CH_LBRACE  = 8'h7b;
	localparam logic [7:0] CH_RBRACE  = 8'h7d;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	localparam logic [15:0] CAP_RESET = 16'd1024;

	// command queue geometry
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

	// one classified input word
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  ch;
		logic        last;
		logic [15:0] len;
		logic        failed;
	} cmd_t;

	// front state seen by the top level
	typedef struct packed {
		logic [15:0] out_count;
		logic        fail;
	} front_status_t;

	function automatic logic passes_unchanged(input logic [7:0] c);
		logic r;
		r = (c inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
			CH_COLON, CH_COMMA, CH_DOT, CH_MINUS, CH_UNDER,
			CH_STAR, CH_LBRACE, CH_RBRACE, CH_DQUOTE});
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_LOWER_A + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

### hw/rtl/urlenc_front.sv
// front part: capacity register, classification and per-string count state
`timescale 1ns / 1ps

module urlenc_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     out_capacity_we,
	input  logic [15:0]              out_capacity_wdata,
	input  logic                     accept,
	input  logic [7:0]               in_byte,
	input  logic                     in_last,
	output logic                     cmd_push,
	output urlenc_pkg::cmd_t         cmd,
	output urlenc_pkg::front_status_t status
);

	logic [15:0] cap_q;
	logic [15:0] count_q;
	logic        fail_q;

	logic        can_emit;
	logic        fits3;
	logic [1:0]  kind;
	logic [7:0]  ch;
	logic [15:0] count_next;
	logic        fail_next;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= urlenc_pkg::CAP_RESET;
		end else if (out_capacity_we) begin
			cap_q <= out_capacity_wdata;
		end
	end

	// classify the byte against the running count
	always_comb begin
		can_emit   = !fail_q && (count_q < cap_q);
		fits3      = ({1'b0, count_q} + 17'd3) < {1'b0, cap_q};
		kind       = urlenc_pkg::KIND_NONE;
		ch         = in_byte;
		count_next = count_q;
		fail_next  = fail_q;
		if (can_emit) begin
			if (urlenc_pkg::passes_unchanged(in_byte)) begin
				kind       = urlenc_pkg::KIND_ONE;
				count_next = count_q + 16'd1;
			end else if (in_byte == urlenc_pkg::CH_SPACE) begin
				kind       = urlenc_pkg::KIND_ONE;
				ch         = urlenc_pkg::CH_PLUS;
				count_next = count_q + 16'd1;
			end else if (fits3) begin
				kind       = urlenc_pkg::KIND_THREE;
				count_next = count_q + 16'd3;
			end else begin
				fail_next = 1'b1;
			end
		end
	end

	// command word for the back part
	always_comb begin
		cmd.kind   = kind;
		cmd.ch     = ch;
		cmd.last   = in_last;
		cmd.len    = fail_next ? 16'd0 : count_next;
		cmd.failed = fail_next;
		cmd_push   = accept && ((kind != urlenc_pkg::KIND_NONE) || in_last);
	end

	// per-string state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 16'd0;
			fail_q  <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				count_q <= 16'd0;
				fail_q  <= 1'b0;
			end else begin
				count_q <= count_next;
				fail_q  <= fail_next;
			end
		end
	end

	assign status.out_count = count_q;
	assign status.fail      = fail_q;

endmodule

### hw/rtl/urlenc_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps

module urlenc_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  urlenc_pkg::cmd_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output urlenc_pkg::cmd_t rdata
);

	urlenc_pkg::cmd_t                   mem_q [urlenc_pkg::CMD_DEPTH];
	logic [urlenc_pkg::CMD_PTR_W-1:0]   wr_ptr_q;
	logic [urlenc_pkg::CMD_PTR_W-1:0]   rd_ptr_q;
	logic [urlenc_pkg::CMD_PTR_W:0]     count_q;

	assign full  = (count_q == (urlenc_pkg::CMD_PTR_W + 1)'(urlenc_pkg::CMD_DEPTH));
	assign avail = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/urlenc_back.sv
// back part: expands commands into result words and holds the output register
`timescale 1ns / 1ps

module urlenc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_avail,
	input  urlenc_pkg::cmd_t cmd,
	output logic             cmd_pop,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic             is_summary,
	output logic             run_end,
	output logic [15:0]      total_length,
	output logic             failed
);

	logic [1:0]  step_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        summ_q;
	logic        end_q;
	logic [15:0] len_q;
	logic        fail_q;

	logic [2:0]  nbytes;
	logic [2:0]  nres;
	logic        final_step;
	logic        load;
	logic [7:0]  next_byte;
	logic        next_summ;

	// result count and the word for the current step
	always_comb begin
		case (cmd.kind)
			urlenc_pkg::KIND_ONE:   nbytes = 3'd1;
			urlenc_pkg::KIND_THREE: nbytes = 3'd3;
			default:                nbytes = 3'd0;
		endcase
		nres       = nbytes + {2'd0, cmd.last};
		final_step = (({1'b0, step_q} + 3'd1) == nres);
		next_summ  = ({1'b0, step_q} >= nbytes);
		next_byte  = 8'd0;
		if (!next_summ) begin
			if (cmd.kind == urlenc_pkg::KIND_ONE) begin
				next_byte = cmd.ch;
			end else begin
				case (step_q)
					2'd0:    next_byte = urlenc_pkg::CH_PERCENT;
					2'd1:    next_byte = urlenc_pkg::hex_digit(cmd.ch[7:4]);
					default: next_byte = urlenc_pkg::hex_digit(cmd.ch[3:0]);
				endcase
			end
		end
	end

	assign load    = cmd_avail && (!out_valid_q || pop);
	assign cmd_pop = load && final_step;

	// step counter within one command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
		end else if (load) begin
			step_q <= final_step ? 2'd0 : step_q + 2'd1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= next_byte;
			summ_q <= next_summ;
			end_q  <= final_step;
			len_q  <= next_summ ? cmd.len : 16'd0;
			fail_q <= next_summ ? cmd.failed : 1'b0;
		end
	end

	assign empty        = !out_valid_q;
	assign out_byte     = byte_q;
	assign is_summary   = summ_q;
	assign run_end      = end_q;
	assign total_length = len_q;
	assign failed       = fail_q;

endmodule

### hw/rtl/url_percent_encoder.sv
// Form-style URL percent encoder, one raw byte per input word. A byte is
// taken in every cycle while the four-entry command queue has room. Each
// byte gives zero, one or three encoded words, and the last byte of a
// string adds one summary word; the output register hands out one word per
// cycle while the reader keeps popping. The capacity register resets to
// 1024; the user must write it only while the block is idle, which the
// block itself does not enforce.
`timescale 1ns / 1ps

module url_percent_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_capacity_we,
	input  logic [15:0] out_capacity_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        is_summary,
	output logic        run_end,
	output logic [15:0] total_length,
	output logic        failed
);

	logic                      accept;
	logic                      fifo_push;
	logic                      fifo_full;
	logic                      fifo_pop;
	logic                      fifo_avail;
	urlenc_pkg::cmd_t          front_cmd;
	urlenc_pkg::cmd_t          head_cmd;
	urlenc_pkg::front_status_t front_st;

	assign full   = fifo_full;
	assign accept = push && !fifo_full;

	// classification front
	urlenc_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.out_capacity_we    (out_capacity_we),
		.out_capacity_wdata (out_capacity_wdata),
		.accept             (accept),
		.in_byte            (in_byte),
		.in_last            (in_last),
		.cmd_push           (fifo_push),
		.cmd                (front_cmd),
		.status             (front_st)
	);

	// command queue
	urlenc_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wdata  (front_cmd),
		.full   (fifo_full),
		.pop    (fifo_pop),
		.avail  (fifo_avail),
		.rdata  (head_cmd)
	);

	// result expansion back
	urlenc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_avail    (fifo_avail),
		.cmd          (head_cmd),
		.cmd_pop      (fifo_pop),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.is_summary   (is_summary),
		.run_end      (run_end),
		.total_length (total_length),
		.failed       (failed)
	);

	// checks
	`include "url_percent_encoder_assert.svh"

	`UPE_ASSERT_NOW(a_no_overflow, fifo_push, !fifo_full, "command queue overflow")
	`UPE_ASSERT_NOW(a_summary_shape, !empty && is_summary, (out_byte == 8'd0) && run_end, "summary word malformed")
	`UPE_ASSERT_NOW(a_byte_shape, !empty && !is_summary, (total_length == 16'd0) && !failed, "byte word carries summary fields")
	`UPE_ASSERT_NEXT(a_state_clear, accept && in_last, (front_st.out_count == 16'd0) && !front_st.fail, "string state not cleared")

endmodule
